### rtl/moving_average_warmup_assert.svh
// Assertion macros shared by the moving average checker.
`ifndef MOVING_AVERAGE_WARMUP_ASSERT_SVH
`define MOVING_AVERAGE_WARMUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MAVW_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("moving average check failed");

// Next-cycle implication, checked outside reset.
`define MAVW_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("moving average check failed");

`endif

### rtl/mavw_pkg.sv
// Package: shared constants and state type of the moving average block.
`timescale 1ns / 1ps

package mavw_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int WINDOW_DEFAULT = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### rtl/mavw_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module mavw_sdiv #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  qbit;

    // One restoring step: bring down the next dividend bit, try the subtract.
    always_comb begin
        trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, div_reg};
        qbit  = (trial >= {1'b0, div_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[DIVIDEND_W-2:0], qbit};
            rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

### rtl/moving_average_warmup.sv
// Top level: sliding-window average of 12-bit samples with warm-up divisor.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_valid / s_ready / s_sample_value carries one sample per
//   request. Result channel m_valid / m_ready / m_average returns exactly one
//   average per sample, in order: the truncated mean of the samples now held
//   in the window (at most WINDOW of them; fewer during warm-up).
//   From accept to m_valid the steps are, in order: the sum update, the
//   bit-serial divider over SUM_W bits, where SUM_W is the running-sum width
//   ($clog2(WINDOW * 4095 + 1), 16 at WINDOW = 16), its done flag, and the
//   load of the output register. One sample is worked at a time and s_ready
//   returns the cycle after the load, so a new request is taken only once
//   the last result is loaded; the divider retires one quotient bit per cycle.
//   The output register holds a finished result while the next sample is
//   taken in; if the receiver still stalls when the next result is ready,
//   the block holds that result and keeps s_ready low until m_ready frees
//   the output register.
//   Reset (aresetn low, synchronous) empties the window: fill count, write
//   position and running sum go to zero. The window memory is not swept;
//   entries not yet written in the first pass are treated as zero.
//
module moving_average_warmup #(
    parameter int WINDOW = mavw_pkg::WINDOW_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mavw_pkg::SAMPLE_W-1:0] s_sample_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mavw_pkg::SAMPLE_W-1:0] m_average
);

    import mavw_pkg::*;

    localparam int SUM_W = $clog2(WINDOW * 4095 + 1);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    state_t state_reg, state_next;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_average_reg;

    logic                accept;
    logic                full;
    logic [SAMPLE_W-1:0] old_value;
    logic                update;
    logic                load;
    logic                div_done;
    logic [SUM_W-1:0]    quotient;

    assign accept = s_valid && s_ready;

    // Positions are written in order from zero, so until the window is full
    // the entry at the write position has never been written: read it as zero.
    assign full      = (fill_reg == CNT_W'(WINDOW));
    assign old_value = full ? rd_data_reg : '0;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid)  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_ready = 1'b0;
        update  = 1'b0;
        load    = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_UPDATE: update  = 1'b1;
            ST_DIV:    ;
            ST_DONE:   load    = !m_valid_reg || m_ready;
            default:   ;
        endcase
    end

    // Window bookkeeping: drop the oldest sample, add the new one, advance.
    always_comb begin
        sum_next  = sum_reg - SUM_W'(old_value) + SUM_W'(sample_reg);
        fill_next = full ? fill_reg : fill_reg + 1'b1;
        pos_next  = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
    end

    // Output register: hold until taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (update) begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end
    end

    // Window memory: read on accept, write back in the update cycle.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= mem[pos_reg];
        end
        if (update) begin
            mem[pos_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample_value;
        end
        if (load) begin
            m_average_reg <= quotient[SAMPLE_W-1:0];
        end
    end

    // Divide the updated sum by the updated fill count, never zero.
    mavw_sdiv #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_sdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (update),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

endmodule

### rtl/mavw_checker.sv
// Checker: port-level properties of the moving average block, bound to the top.
`timescale 1ns / 1ps
`include "moving_average_warmup_assert.svh"

module mavw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [mavw_pkg::SAMPLE_W-1:0] s_sample_value,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mavw_pkg::SAMPLE_W-1:0] m_average
);

    import mavw_pkg::*;

    logic s_accept;
    logic stalled;

    assign s_accept = s_valid && s_ready;
    assign stalled  = m_valid && !m_ready;

    // A stalled result holds.
    `MAVW_ASSERT_NEXT(a_hold_result, aclk, aresetn, stalled, m_valid && $stable(m_average))

    // One sample in flight: no new request right after an accept.
    `MAVW_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_accept, !s_ready)

    // A result never appears the cycle after its sample is taken.
    `MAVW_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_accept, !$rose(m_valid))

    // Result valid is always known while input is offered ready.
    `MAVW_ASSERT_NOW(a_ready_known, aclk, aresetn, s_ready, !$isunknown(m_valid))

endmodule

bind moving_average_warmup mavw_checker u_checker (.*);
